FILE: rtl/core/e2q_pkg.sv
package e2q_pkg;

    localparam int ROM_DATA_BITS = 15;
    localparam int TRIG_BITS     = 16;
    localparam int PAIR_BITS     = 32;
    localparam int TRIPLE_BITS   = 47;
    localparam int SUM_BITS      = 48;
    localparam int QUAT_BITS     = 16;
    localparam int ROUND_SHIFT   = 30;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic rom;
        logic trig;
        logic pair;
        logic triple;
        logic sum;
    } stage_en_t;

    // Quarter-wave sine entry: odd Taylor series to the 15th power in Q30,
    // rounded to Q15 and clipped below one.
    function automatic logic [ROM_DATA_BITS-1:0] rom_entry(input int unsigned i,
                                                           input int unsigned addr_bits);
        logic [63:0] top;
        logic [63:0] pos;
        logic [63:0] x;
        logic [63:0] theta;
        logic [63:0] term;
        logic [63:0] q;
        longint      sum;
        int          k;
        top = 64'd1 << addr_bits;
        pos = 64'(i);
        if (pos > top)
        begin
            pos = top;
        end
        x     = pos << (30 - addr_bits);
        theta = (x * HALF_PI_Q30) >> 30;
        term  = theta;
        sum   = longint'(theta);
        for (k = 1; k <= 7; k++)
        begin
            term = (((term * theta) >> 30) * theta) >> 30;
            case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                default: term = term / 64'd210;
            endcase
            if ((k % 2) == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        q = (64'(sum) + 64'd16384) >> 15;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        return q[ROM_DATA_BITS-1:0];
    endfunction

endpackage

FILE: rtl/core/euler_to_quaternion_top.sv
// Channel  Direction  Handshake             Payload
// in       sink       in_valid / in_stall   roll_angle, pitch_angle, yaw_angle
// out      source     out_valid / out_stall quat_w, quat_x, quat_y, quat_z
//
// One transaction per cycle sustained while out_stall is low.
// Stages: sine ROM read, sine/cosine select, pair products, triple products, sum, round and clip.
// Reset (rst_n, async) clears the stage valid bits only; no ROM clearing is needed.
// A stage loads whenever it is empty or the stage after it moves, so bubbles close up.
// in_stall rises only when all five stages hold a transaction and out_stall is high.
module euler_to_quaternion_top #(
    parameter int ANGLE_BITS           = 16,
    parameter int SINE_TABLE_ADDR_BITS = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [ANGLE_BITS-1:0]                 roll_angle,
    input  logic [ANGLE_BITS-1:0]                 pitch_angle,
    input  logic [ANGLE_BITS-1:0]                 yaw_angle,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [e2q_pkg::QUAT_BITS-1:0]  quat_w,
    output logic signed [e2q_pkg::QUAT_BITS-1:0]  quat_x,
    output logic signed [e2q_pkg::QUAT_BITS-1:0]  quat_y,
    output logic signed [e2q_pkg::QUAT_BITS-1:0]  quat_z
);
    import e2q_pkg::*;

    logic [5:1] valid_reg;
    logic [5:1] valid_next;
    logic [5:1] rdy;
    stage_en_t  en;

    logic signed [TRIG_BITS-1:0] sr;
    logic signed [TRIG_BITS-1:0] cr;
    logic signed [TRIG_BITS-1:0] sp;
    logic signed [TRIG_BITS-1:0] cp;
    logic signed [TRIG_BITS-1:0] sy;
    logic signed [TRIG_BITS-1:0] cy;

    always_comb
    begin
        rdy[5] = !valid_reg[5] || !out_stall;
        rdy[4] = !valid_reg[4] || rdy[5];
        rdy[3] = !valid_reg[3] || rdy[4];
        rdy[2] = !valid_reg[2] || rdy[3];
        rdy[1] = !valid_reg[1] || rdy[2];

        en.rom    = rdy[1];
        en.trig   = rdy[2];
        en.pair   = rdy[3];
        en.triple = rdy[4];
        en.sum    = rdy[5];

        valid_next[1] = rdy[1] ? in_valid     : valid_reg[1];
        valid_next[2] = rdy[2] ? valid_reg[1] : valid_reg[2];
        valid_next[3] = rdy[3] ? valid_reg[2] : valid_reg[3];
        valid_next[4] = rdy[4] ? valid_reg[3] : valid_reg[4];
        valid_next[5] = rdy[5] ? valid_reg[4] : valid_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !rdy[1];
    assign out_valid = valid_reg[5];

    e2q_sincos #(
        .ANGLE_BITS           (ANGLE_BITS),
        .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS)
    ) u_roll (
        .clk     (clk),
        .en      (en),
        .angle   (roll_angle),
        .sin_val (sr),
        .cos_val (cr)
    );

    e2q_sincos #(
        .ANGLE_BITS           (ANGLE_BITS),
        .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS)
    ) u_pitch (
        .clk     (clk),
        .en      (en),
        .angle   (pitch_angle),
        .sin_val (sp),
        .cos_val (cp)
    );

    e2q_sincos #(
        .ANGLE_BITS           (ANGLE_BITS),
        .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS)
    ) u_yaw (
        .clk     (clk),
        .en      (en),
        .angle   (yaw_angle),
        .sin_val (sy),
        .cos_val (cy)
    );

    e2q_quat u_quat (
        .clk    (clk),
        .en     (en),
        .sr     (sr),
        .cr     (cr),
        .sp     (sp),
        .cp     (cp),
        .sy     (sy),
        .cy     (cy),
        .quat_w (quat_w),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z)
    );

endmodule

FILE: rtl/core/e2q_sincos.sv
module e2q_sincos #(
    parameter int ANGLE_BITS           = 16,
    parameter int SINE_TABLE_ADDR_BITS = 10
) (
    input  logic                                  clk,
    input  e2q_pkg::stage_en_t                    en,
    input  logic [ANGLE_BITS-1:0]                 angle,
    output logic signed [e2q_pkg::TRIG_BITS-1:0]  sin_val,
    output logic signed [e2q_pkg::TRIG_BITS-1:0]  cos_val
);
    import e2q_pkg::*;

    localparam int AB       = SINE_TABLE_ADDR_BITS;
    localparam int OFF_BITS = ANGLE_BITS - 1;
    localparam int ROM_TOP  = 1 << AB;

    logic [ROM_DATA_BITS-1:0] rom_mem [0:ROM_TOP];

    logic [AB-1:0]              idx;
    logic [AB:0]                idx_lo;
    logic [AB:0]                idx_hi;
    logic [ROM_DATA_BITS-1:0]   lo_reg;
    logic [ROM_DATA_BITS-1:0]   hi_reg;
    logic                       quad_reg;
    logic signed [TRIG_BITS-1:0] lo_s;
    logic signed [TRIG_BITS-1:0] hi_s;
    logic signed [TRIG_BITS-1:0] sin_next;
    logic signed [TRIG_BITS-1:0] cos_next;
    logic signed [TRIG_BITS-1:0] sin_reg;
    logic signed [TRIG_BITS-1:0] cos_reg;

    for (genvar g = 0; g <= ROM_TOP; g++)
    begin : g_rom
        localparam logic [ROM_DATA_BITS-1:0] ENTRY = rom_entry(g, AB);
        assign rom_mem[g] = ENTRY;
    end

    if (OFF_BITS >= AB)
    begin : g_idx_trunc
        assign idx = angle[OFF_BITS-1 -: AB];
    end
    else
    begin : g_idx_ext
        assign idx = {angle[OFF_BITS-1:0], {(AB - OFF_BITS){1'b0}}};
    end

    assign idx_lo = {1'b0, idx};
    assign idx_hi = (AB + 1)'(ROM_TOP) - idx_lo;

    always_ff @(posedge clk)
    begin
        if (en.rom)
        begin
            lo_reg   <= rom_mem[idx_lo];
            hi_reg   <= rom_mem[idx_hi];
            quad_reg <= angle[ANGLE_BITS-1];
        end
    end

    // second quadrant of the half angle: swap and negate cosine
    always_comb
    begin
        lo_s = signed'({1'b0, lo_reg});
        hi_s = signed'({1'b0, hi_reg});
        if (quad_reg)
        begin
            sin_next = hi_s;
            cos_next = -lo_s;
        end
        else
        begin
            sin_next = lo_s;
            cos_next = hi_s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.trig)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

FILE: rtl/core/e2q_quat.sv
module e2q_quat (
    input  logic                                  clk,
    input  e2q_pkg::stage_en_t                    en,
    input  logic signed [e2q_pkg::TRIG_BITS-1:0]  sr,
    input  logic signed [e2q_pkg::TRIG_BITS-1:0]  cr,
    input  logic signed [e2q_pkg::TRIG_BITS-1:0]  sp,
    input  logic signed [e2q_pkg::TRIG_BITS-1:0]  cp,
    input  logic signed [e2q_pkg::TRIG_BITS-1:0]  sy,
    input  logic signed [e2q_pkg::TRIG_BITS-1:0]  cy,
    output logic signed [e2q_pkg::QUAT_BITS-1:0]  quat_w,
    output logic signed [e2q_pkg::QUAT_BITS-1:0]  quat_x,
    output logic signed [e2q_pkg::QUAT_BITS-1:0]  quat_y,
    output logic signed [e2q_pkg::QUAT_BITS-1:0]  quat_z
);
    import e2q_pkg::*;

    localparam int Q_BITS = SUM_BITS - ROUND_SHIFT;

    function automatic logic signed [QUAT_BITS-1:0] round_sat(
        input logic signed [SUM_BITS-1:0] s
    );
        logic signed [SUM_BITS-1:0] r;
        logic signed [Q_BITS-1:0]   q;
        logic signed [Q_BITS-1:0]   q_max;
        logic signed [Q_BITS-1:0]   q_min;
        r     = s + (SUM_BITS'(1) <<< (ROUND_SHIFT - 1));
        q     = r[SUM_BITS-1:ROUND_SHIFT];
        q_max = Q_BITS'(32767);
        q_min = -Q_BITS'(32768);
        if (q > q_max)
        begin
            return QUAT_BITS'(32767);
        end
        else if (q < q_min)
        begin
            return QUAT_BITS'(-32768);
        end
        return q[QUAT_BITS-1:0];
    endfunction

    logic signed [PAIR_BITS-1:0]   cycp_reg;
    logic signed [PAIR_BITS-1:0]   sysp_reg;
    logic signed [PAIR_BITS-1:0]   cysp_reg;
    logic signed [PAIR_BITS-1:0]   sycp_reg;
    logic signed [TRIG_BITS-1:0]   sr_reg;
    logic signed [TRIG_BITS-1:0]   cr_reg;

    logic signed [TRIPLE_BITS-1:0] w_a_reg;
    logic signed [TRIPLE_BITS-1:0] w_b_reg;
    logic signed [TRIPLE_BITS-1:0] x_a_reg;
    logic signed [TRIPLE_BITS-1:0] x_b_reg;
    logic signed [TRIPLE_BITS-1:0] y_a_reg;
    logic signed [TRIPLE_BITS-1:0] y_b_reg;
    logic signed [TRIPLE_BITS-1:0] z_a_reg;
    logic signed [TRIPLE_BITS-1:0] z_b_reg;

    logic signed [SUM_BITS-1:0]    w_sum;
    logic signed [SUM_BITS-1:0]    x_sum;
    logic signed [SUM_BITS-1:0]    y_sum;
    logic signed [SUM_BITS-1:0]    z_sum;

    logic signed [QUAT_BITS-1:0]   w_reg;
    logic signed [QUAT_BITS-1:0]   x_reg;
    logic signed [QUAT_BITS-1:0]   y_reg;
    logic signed [QUAT_BITS-1:0]   z_reg;

    always_ff @(posedge clk)
    begin
        if (en.pair)
        begin
            cycp_reg <= PAIR_BITS'(cy * cp);
            sysp_reg <= PAIR_BITS'(sy * sp);
            cysp_reg <= PAIR_BITS'(cy * sp);
            sycp_reg <= PAIR_BITS'(sy * cp);
            sr_reg   <= sr;
            cr_reg   <= cr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.triple)
        begin
            w_a_reg <= TRIPLE_BITS'(cycp_reg * cr_reg);
            w_b_reg <= TRIPLE_BITS'(sysp_reg * sr_reg);
            x_a_reg <= TRIPLE_BITS'(cycp_reg * sr_reg);
            x_b_reg <= TRIPLE_BITS'(sysp_reg * cr_reg);
            y_a_reg <= TRIPLE_BITS'(sycp_reg * sr_reg);
            y_b_reg <= TRIPLE_BITS'(cysp_reg * cr_reg);
            z_a_reg <= TRIPLE_BITS'(sycp_reg * cr_reg);
            z_b_reg <= TRIPLE_BITS'(cysp_reg * sr_reg);
        end
    end

    assign w_sum = SUM_BITS'(w_a_reg) + SUM_BITS'(w_b_reg);
    assign x_sum = SUM_BITS'(x_a_reg) - SUM_BITS'(x_b_reg);
    assign y_sum = SUM_BITS'(y_a_reg) + SUM_BITS'(y_b_reg);
    assign z_sum = SUM_BITS'(z_a_reg) - SUM_BITS'(z_b_reg);

    always_ff @(posedge clk)
    begin
        if (en.sum)
        begin
            w_reg <= round_sat(w_sum);
            x_reg <= round_sat(x_sum);
            y_reg <= round_sat(y_sum);
            z_reg <= round_sat(z_sum);
        end
    end

    assign quat_w = w_reg;
    assign quat_x = x_reg;
    assign quat_y = y_reg;
    assign quat_z = z_reg;

endmodule
